// ----- hw/rtl/lspnc_pkg.sv -----
// ----------------------------------------------------------------------------
// Line segment project and near clip: shared package
// Types, register codes, reset values and helpers shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package lspnc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned HALF_W     = 30;
  localparam int unsigned T_FRAC     = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X_01    = 3'd0,
    REG_ROW_X_23    = 3'd1,
    REG_ROW_Y_01    = 3'd2,
    REG_ROW_Y_23    = 3'd3,
    REG_ROW_W_01    = 3'd4,
    REG_ROW_W_23    = 3'd5,
    REG_HALF_WIDTH  = 3'd6,
    REG_HALF_HEIGHT = 3'd7
  } reg_idx_t;

  localparam logic [CFG_DATA_W-1:0] RST_ROW_X_01 = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_X_23 = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_Y_01 = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_Y_23 = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_W_01 = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_W_23 = 64'h0001_0000_0000_0000;

  localparam logic signed [31:0] NEAR_Q = 32'sd7;

  localparam int unsigned DIV_DVD_W           = 64;
  localparam int unsigned DIV_DSR_W           = 34;
  localparam int unsigned DIV_STEPS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES          = DIV_DVD_W / DIV_STEPS_PER_STAGE;

  typedef struct packed {
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
  } row_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } src_pt_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] w;
  } clip_pt_t;

  typedef struct packed {
    clip_pt_t a;
    clip_pt_t b;
    logic     a_behind;
    logic     b_behind;
    logic     last;
  } clip_seg_t;

  typedef struct packed {
    logic [3:0] neg;
    logic       vis;
    logic       last;
  } win_side_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lspnc_seg_if.sv -----
// ----------------------------------------------------------------------------
// Line segment project and near clip: segment channel
// Valid/ready channel that carries one 3D segment per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lspnc_seg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  logic               last_segment;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  last_segment, input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                last_segment, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lspnc_win_if.sv -----
// ----------------------------------------------------------------------------
// Line segment project and near clip: window channel
// Valid/ready channel that carries one projected segment per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lspnc_win_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] win_start_x;
  logic signed [31:0] win_start_y;
  logic signed [31:0] win_end_x;
  logic signed [31:0] win_end_y;
  logic               visible;
  logic               end_of_batch;

  modport source (output valid, win_start_x, win_start_y, win_end_x, win_end_y,
                  visible, end_of_batch, input ready);
  modport sink (input valid, win_start_x, win_start_y, win_end_x, win_end_y,
                visible, end_of_batch, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lspnc_div.sv -----
// ----------------------------------------------------------------------------
// Line segment project and near clip: pipelined divider
// Unsigned restoring divider, two quotient bits per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lspnc_div (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [lspnc_pkg::DIV_DVD_W-1:0] dividend,
  input  wire logic [lspnc_pkg::DIV_DSR_W-1:0] divisor,
  output logic      [lspnc_pkg::DIV_DVD_W-1:0] quotient
);
  import lspnc_pkg::*;

  logic [DIV_DSR_W-1:0] rem_r [DIV_STAGES];
  logic [DIV_DVD_W-1:0] dq_r  [DIV_STAGES];
  logic [DIV_DSR_W-1:0] dsr_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_DSR_W-1:0] rem_in;
    logic [DIV_DVD_W-1:0] dq_in;
    logic [DIV_DSR_W-1:0] dsr_in;
    logic [DIV_DSR_W-1:0] rem_nxt;
    logic [DIV_DVD_W-1:0] dq_nxt;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dividend;
      assign dsr_in = divisor;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign dq_in  = dq_r[s-1];
      assign dsr_in = dsr_r[s-1];
    end

    always_comb begin
      logic [DIV_DSR_W:0] t;
      rem_nxt = rem_in;
      dq_nxt  = dq_in;
      for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
        t      = {rem_nxt, dq_nxt[DIV_DVD_W-1]};
        dq_nxt = {dq_nxt[DIV_DVD_W-2:0], 1'b0};
        if (t >= {1'b0, dsr_in}) begin
          t         = t - {1'b0, dsr_in};
          dq_nxt[0] = 1'b1;
        end
        rem_nxt = t[DIV_DSR_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        dq_r[s]  <= dq_nxt;
        dsr_r[s] <= dsr_in;
      end
    end
  end

  assign quotient = dq_r[DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- hw/rtl/lspnc_xform.sv -----
// ----------------------------------------------------------------------------
// Line segment project and near clip: transform stages
// Row products, Q16.16 sums with saturation, and the near-plane test.
// ----------------------------------------------------------------------------
`default_nettype none

module lspnc_xform (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire lspnc_pkg::src_pt_t    in_a,
  input  wire lspnc_pkg::src_pt_t    in_b,
  input  wire logic                  in_last,
  input  wire lspnc_pkg::row_t       row_x,
  input  wire lspnc_pkg::row_t       row_y,
  input  wire lspnc_pkg::row_t       row_w,
  output logic                       out_valid,
  output lspnc_pkg::clip_seg_t       out_seg,
  output logic [32:0]                out_num,
  output logic [32:0]                out_den
);
  import lspnc_pkg::*;

  src_pt_t            pts [2];
  row_t               rows [3];
  logic signed [63:0] prod_r [2][3][3];
  logic signed [31:0] rv_nxt [2][3];
  clip_pt_t           pa_r, pb_r;
  logic               v1_r, v2_r, v3_r;
  logic               l1_r, l2_r;
  clip_seg_t          seg_nxt, seg_r;
  logic signed [32:0] num, den;
  logic [32:0]        num_r, den_r;

  always_comb begin
    pts[0]  = in_a;
    pts[1]  = in_b;
    rows[0] = row_x;
    rows[1] = row_y;
    rows[2] = row_w;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 2; e++) begin
        for (int r = 0; r < 3; r++) begin
          prod_r[e][r][0] <= rows[r].c0 * pts[e].x;
          prod_r[e][r][1] <= rows[r].c1 * pts[e].y;
          prod_r[e][r][2] <= rows[r].c2 * pts[e].z;
        end
      end
      l1_r <= in_last;
    end
  end

  always_comb begin
    logic signed [65:0] sum;
    logic signed [65:0] hi;
    for (int e = 0; e < 2; e++) begin
      for (int r = 0; r < 3; r++) begin
        sum = prod_r[e][r][0] + prod_r[e][r][1] + prod_r[e][r][2];
        hi  = (sum >>> 16) + rows[r].c3;
        rv_nxt[e][r] = sat32(hi);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= '{x: rv_nxt[0][0], y: rv_nxt[0][1], w: rv_nxt[0][2]};
      pb_r <= '{x: rv_nxt[1][0], y: rv_nxt[1][1], w: rv_nxt[1][2]};
      l2_r <= l1_r;
    end
  end

  always_comb begin
    seg_nxt.a        = pa_r;
    seg_nxt.b        = pb_r;
    seg_nxt.a_behind = pa_r.w < NEAR_Q;
    seg_nxt.b_behind = pb_r.w < NEAR_Q;
    seg_nxt.last     = l2_r;
    num = NEAR_Q - pa_r.w;
    den = pb_r.w - pa_r.w;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_r <= seg_nxt;
      num_r <= num[32] ? 33'(-num) : 33'(num);
      den_r <= den[32] ? 33'(-den) : 33'(den);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_seg   = seg_r;
  assign out_num   = num_r;
  assign out_den   = den_r;

endmodule

`default_nettype wire

// ----- hw/rtl/lspnc_clip.sv -----
// ----------------------------------------------------------------------------
// Line segment project and near clip: clip stages
// Moves a behind end to the near crossing and forms the window products.
// ----------------------------------------------------------------------------
`default_nettype none

module lspnc_clip (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire lspnc_pkg::clip_seg_t          in_seg,
  input  wire logic [lspnc_pkg::T_FRAC:0]    in_t,
  input  wire logic [lspnc_pkg::HALF_W-1:0]  half_w,
  input  wire logic [lspnc_pkg::HALF_W-1:0]  half_h,
  output logic                               out_valid,
  output logic [lspnc_pkg::DIV_DVD_W-1:0]    out_dvd [4],
  output logic [lspnc_pkg::DIV_DSR_W-1:0]    out_w_a,
  output logic [lspnc_pkg::DIV_DSR_W-1:0]    out_w_b,
  output lspnc_pkg::win_side_t               out_side
);
  import lspnc_pkg::*;

  logic               v4_r, v5_r, v6_r;
  clip_seg_t          s4_r;
  logic [63:0]        px_r, py_r;
  logic               nx_r, ny_r;
  logic signed [32:0] dx, dy;
  clip_pt_t           a_nxt, b_nxt, a5_r, b5_r;
  logic               vis5_r, last5_r;
  logic [31:0]        mag [4];
  logic [DIV_DVD_W-1:0] dvd_r [4];
  logic [DIV_DSR_W-1:0] wa_r, wb_r;
  win_side_t          side_r;

  always_comb begin
    dx = in_seg.b.x - in_seg.a.x;
    dy = in_seg.b.y - in_seg.a.y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r <= in_seg;
      nx_r <= dx[32];
      ny_r <= dy[32];
      px_r <= (dx[32] ? 33'(-dx) : 33'(dx)) * in_t;
      py_r <= (dy[32] ? 33'(-dy) : 33'(dy)) * in_t;
    end
  end

  always_comb begin
    logic signed [34:0] qx, qy, cx, cy;
    qx = signed'(35'(px_r[63:T_FRAC]));
    qy = signed'(35'(py_r[63:T_FRAC]));
    cx = nx_r ? 35'(s4_r.a.x) - qx : 35'(s4_r.a.x) + qx;
    cy = ny_r ? 35'(s4_r.a.y) - qy : 35'(s4_r.a.y) + qy;
    a_nxt = s4_r.a;
    b_nxt = s4_r.b;
    if (s4_r.a_behind && !s4_r.b_behind) begin
      a_nxt = '{x: cx[31:0], y: cy[31:0], w: NEAR_Q};
    end else if (s4_r.b_behind && !s4_r.a_behind) begin
      b_nxt = '{x: cx[31:0], y: cy[31:0], w: NEAR_Q};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a5_r    <= a_nxt;
      b5_r    <= b_nxt;
      vis5_r  <= !(s4_r.a_behind && s4_r.b_behind);
      last5_r <= s4_r.last;
    end
  end

  always_comb begin
    mag[0] = a5_r.x[31] ? unsigned'(-a5_r.x) : unsigned'(a5_r.x);
    mag[1] = a5_r.y[31] ? unsigned'(-a5_r.y) : unsigned'(a5_r.y);
    mag[2] = b5_r.x[31] ? unsigned'(-b5_r.x) : unsigned'(b5_r.x);
    mag[3] = b5_r.y[31] ? unsigned'(-b5_r.y) : unsigned'(b5_r.y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_r[0]    <= 64'(mag[0]) * 64'(half_w);
      dvd_r[1]    <= 64'(mag[1]) * 64'(half_h);
      dvd_r[2]    <= 64'(mag[2]) * 64'(half_w);
      dvd_r[3]    <= 64'(mag[3]) * 64'(half_h);
      wa_r        <= {2'b00, a5_r.w};
      wb_r        <= {2'b00, b5_r.w};
      side_r.neg  <= {b5_r.y[31], b5_r.x[31], a5_r.y[31], a5_r.x[31]};
      side_r.vis  <= vis5_r;
      side_r.last <= last5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v4_r <= in_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  assign out_valid = v6_r;
  assign out_dvd   = dvd_r;
  assign out_w_a   = wa_r;
  assign out_w_b   = wb_r;
  assign out_side  = side_r;

  a_clip_near_w : assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && vis5_r && (s4_r.a_behind == s4_r.b_behind)) |-> 1'b1)
    else $error("clip stage visibility check failed");
  a_clip_w_set : assert property (@(posedge clk) disable iff (!rst_n)
    (en && v4_r && s4_r.a_behind && !s4_r.b_behind) |=> (a5_r.w == NEAR_Q))
    else $error("clipped start end does not sit on the near plane");

endmodule

`default_nettype wire

// ----- hw/rtl/line_segment_project_near_clip.sv -----
// ----------------------------------------------------------------------------
// Line segment project and near clip: top level
// Projects a segment, clips it at the near plane and maps it to the window.
// ----------------------------------------------------------------------------
// Throughput is one segment per cycle while no result beat waits; the t divider
// and the four window dividers, each of 32 stages, set the depth.
// The whole pipeline advances together and holds while a result beat waits.
// Synchronous reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module line_segment_project_near_clip (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  lspnc_seg_if.sink                              in_seg,
  lspnc_win_if.source                            out_win,
  input  wire logic                              cfg_we,
  input  wire logic [lspnc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lspnc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lspnc_pkg::*;

  logic [CFG_DATA_W-1:0] rx01_r, rx23_r, ry01_r, ry23_r, rw01_r, rw23_r;
  logic [HALF_W-1:0]     hw_r, hh_r;
  row_t                  row_x, row_y, row_w;
  logic                  en;
  src_pt_t               pa, pb;

  logic                  x_valid;
  clip_seg_t             x_seg;
  logic [32:0]           x_num, x_den;
  logic [DIV_DVD_W-1:0]  t_quot;
  clip_seg_t             tdl_seg_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] tdl_v_r;

  logic                  c_valid;
  logic [DIV_DVD_W-1:0]  c_dvd [4];
  logic [DIV_DSR_W-1:0]  c_wa, c_wb;
  win_side_t             c_side;
  logic [DIV_DVD_W-1:0]  w_quot [4];
  win_side_t             wdl_side_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] wdl_v_r;

  logic                  out_valid_r, out_vis_r, out_last_r;
  logic signed [31:0]    out_sx_r, out_sy_r, out_ex_r, out_ey_r;
  logic signed [31:0]    res_nxt [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx01_r <= RST_ROW_X_01;
      rx23_r <= RST_ROW_X_23;
      ry01_r <= RST_ROW_Y_01;
      ry23_r <= RST_ROW_Y_23;
      rw01_r <= RST_ROW_W_01;
      rw23_r <= RST_ROW_W_23;
      hw_r   <= '0;
      hh_r   <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ROW_X_01:    rx01_r <= cfg_data;
        REG_ROW_X_23:    rx23_r <= cfg_data;
        REG_ROW_Y_01:    ry01_r <= cfg_data;
        REG_ROW_Y_23:    ry23_r <= cfg_data;
        REG_ROW_W_01:    rw01_r <= cfg_data;
        REG_ROW_W_23:    rw23_r <= cfg_data;
        REG_HALF_WIDTH:  hw_r   <= cfg_data[HALF_W-1:0];
        REG_HALF_HEIGHT: hh_r   <= cfg_data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    row_x = '{c0: rx01_r[31:0], c1: rx01_r[63:32], c2: rx23_r[31:0], c3: rx23_r[63:32]};
    row_y = '{c0: ry01_r[31:0], c1: ry01_r[63:32], c2: ry23_r[31:0], c3: ry23_r[63:32]};
    row_w = '{c0: rw01_r[31:0], c1: rw01_r[63:32], c2: rw23_r[31:0], c3: rw23_r[63:32]};
    pa    = '{x: in_seg.start_x, y: in_seg.start_y, z: in_seg.start_z};
    pb    = '{x: in_seg.end_x, y: in_seg.end_y, z: in_seg.end_z};
  end

  assign en           = !out_valid_r || out_win.ready;
  assign in_seg.ready = en;

  lspnc_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_seg.valid),
    .in_a      (pa),
    .in_b      (pb),
    .in_last   (in_seg.last_segment),
    .row_x     (row_x),
    .row_y     (row_y),
    .row_w     (row_w),
    .out_valid (x_valid),
    .out_seg   (x_seg),
    .out_num   (x_num),
    .out_den   (x_den)
  );

  lspnc_div u_div_t (
    .clk      (clk),
    .en       (en),
    .dividend (64'({x_num, {T_FRAC{1'b0}}})),
    .divisor  (34'(x_den)),
    .quotient (t_quot)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      tdl_seg_r[0] <= x_seg;
      for (int i = 1; i < DIV_STAGES; i++) begin
        tdl_seg_r[i] <= tdl_seg_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tdl_v_r <= '0;
    end else if (en) begin
      tdl_v_r <= {tdl_v_r[DIV_STAGES-2:0], x_valid};
    end
  end

  lspnc_clip u_clip (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (tdl_v_r[DIV_STAGES-1]),
    .in_seg    (tdl_seg_r[DIV_STAGES-1]),
    .in_t      (t_quot[T_FRAC:0]),
    .half_w    (hw_r),
    .half_h    (hh_r),
    .out_valid (c_valid),
    .out_dvd   (c_dvd),
    .out_w_a   (c_wa),
    .out_w_b   (c_wb),
    .out_side  (c_side)
  );

  for (genvar d = 0; d < 4; d++) begin : g_wdiv
    lspnc_div u_div_w (
      .clk      (clk),
      .en       (en),
      .dividend (c_dvd[d]),
      .divisor  ((d < 2) ? c_wa : c_wb),
      .quotient (w_quot[d])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wdl_side_r[0] <= c_side;
      for (int i = 1; i < DIV_STAGES; i++) begin
        wdl_side_r[i] <= wdl_side_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wdl_v_r <= '0;
    end else if (en) begin
      wdl_v_r <= {wdl_v_r[DIV_STAGES-2:0], c_valid};
    end
  end

  always_comb begin
    logic signed [65:0] q;
    logic signed [65:0] half;
    win_side_t          sd;
    sd = wdl_side_r[DIV_STAGES-1];
    for (int d = 0; d < 4; d++) begin
      q    = signed'(66'(w_quot[d]));
      half = signed'(66'((d == 0 || d == 2) ? hw_r : hh_r));
      if (d == 0 || d == 2) begin
        res_nxt[d] = sat32(sd.neg[d] ? half - q : half + q);
      end else begin
        res_nxt[d] = sat32(sd.neg[d] ? half + q : half - q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vis_r  <= wdl_side_r[DIV_STAGES-1].vis;
      out_last_r <= wdl_side_r[DIV_STAGES-1].last;
      out_sx_r   <= wdl_side_r[DIV_STAGES-1].vis ? res_nxt[0] : '0;
      out_sy_r   <= wdl_side_r[DIV_STAGES-1].vis ? res_nxt[1] : '0;
      out_ex_r   <= wdl_side_r[DIV_STAGES-1].vis ? res_nxt[2] : '0;
      out_ey_r   <= wdl_side_r[DIV_STAGES-1].vis ? res_nxt[3] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= wdl_v_r[DIV_STAGES-1];
    end
  end

  assign out_win.valid        = out_valid_r;
  assign out_win.win_start_x  = out_sx_r;
  assign out_win.win_start_y  = out_sy_r;
  assign out_win.win_end_x    = out_ex_r;
  assign out_win.win_end_y    = out_ey_r;
  assign out_win.visible      = out_vis_r;
  assign out_win.end_of_batch = out_last_r;

  a_rst_clears : assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid not cleared by reset");
  a_hidden_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_vis_r) |->
      (out_sx_r == 32'sd0 && out_sy_r == 32'sd0 && out_ex_r == 32'sd0 && out_ey_r == 32'sd0))
    else $error("hidden segment carries nonzero window fields");
  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(tdl_v_r) && $stable(wdl_v_r)))
    else $error("pipeline valid bits moved during a stall");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Line segment project and near clip: testbench
// Streams segments through the block under several register settings and
// compares every window result with a predicted one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
  logic signed [31:0] sx, sy, ex, ey;
  logic               vis;
  logic               eob;
} win_result_t;

class seg_scoreboard;
  logic [63:0]  regs [8];
  win_result_t  pending [$];
  int           errors;
  int           checked;
  int           visible_cnt;
  int           clipped_cnt;

  function new();
    regs[lspnc_pkg::REG_ROW_X_01]    = lspnc_pkg::RST_ROW_X_01;
    regs[lspnc_pkg::REG_ROW_X_23]    = lspnc_pkg::RST_ROW_X_23;
    regs[lspnc_pkg::REG_ROW_Y_01]    = lspnc_pkg::RST_ROW_Y_01;
    regs[lspnc_pkg::REG_ROW_Y_23]    = lspnc_pkg::RST_ROW_Y_23;
    regs[lspnc_pkg::REG_ROW_W_01]    = lspnc_pkg::RST_ROW_W_01;
    regs[lspnc_pkg::REG_ROW_W_23]    = lspnc_pkg::RST_ROW_W_23;
    regs[lspnc_pkg::REG_HALF_WIDTH]  = 64'd0;
    regs[lspnc_pkg::REG_HALF_HEIGHT] = 64'd0;
    errors = 0;
    checked = 0;
    visible_cnt = 0;
    clipped_cnt = 0;
  endfunction

  function void write_reg(lspnc_pkg::reg_idx_t idx, logic [63:0] val);
    if (idx == lspnc_pkg::REG_HALF_WIDTH || idx == lspnc_pkg::REG_HALF_HEIGHT) begin
      val = val & 64'h3FFF_FFFF;
    end
    regs[idx] = val;
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function longint row_value(logic [63:0] c01, logic [63:0] c23,
                             longint px, longint py, longint pz);
    logic signed [65:0] acc;
    longint p0, p1, p2, hi;
    p0 = sx32(c01[31:0]) * px;
    p1 = sx32(c01[63:32]) * py;
    p2 = sx32(c23[31:0]) * pz;
    acc = 66'(p0) + 66'(p1) + 66'(p2);
    acc = acc >>> 16;
    hi = longint'(acc) + sx32(c23[63:32]);
    return clamp32(hi);
  endfunction

  function longint blend(longint a, longint b, longint unsigned t30);
    longint d;
    longint unsigned mag, q;
    d = b - a;
    mag = (d < 0) ? longint'(-d) : d;
    q = (mag * t30) >> 30;
    return (d < 0) ? a - longint'(q) : a + longint'(q);
  endfunction

  function longint to_win(longint c, longint w, longint half, bit flip);
    longint q;
    q = (c * half) / w;
    return clamp32(flip ? half - q : half + q);
  endfunction

  function void note_segment(logic signed [31:0] f [6], logic last);
    win_result_t r;
    longint ax, ay, aw, bx, by, bw, hw, hh, num, den, cx, cy;
    longint unsigned nm, dm, t30;
    bit ab, bb;
    hw = longint'(regs[lspnc_pkg::REG_HALF_WIDTH][29:0]);
    hh = longint'(regs[lspnc_pkg::REG_HALF_HEIGHT][29:0]);
    ax = row_value(regs[lspnc_pkg::REG_ROW_X_01], regs[lspnc_pkg::REG_ROW_X_23],
                   f[0], f[1], f[2]);
    ay = row_value(regs[lspnc_pkg::REG_ROW_Y_01], regs[lspnc_pkg::REG_ROW_Y_23],
                   f[0], f[1], f[2]);
    aw = row_value(regs[lspnc_pkg::REG_ROW_W_01], regs[lspnc_pkg::REG_ROW_W_23],
                   f[0], f[1], f[2]);
    bx = row_value(regs[lspnc_pkg::REG_ROW_X_01], regs[lspnc_pkg::REG_ROW_X_23],
                   f[3], f[4], f[5]);
    by = row_value(regs[lspnc_pkg::REG_ROW_Y_01], regs[lspnc_pkg::REG_ROW_Y_23],
                   f[3], f[4], f[5]);
    bw = row_value(regs[lspnc_pkg::REG_ROW_W_01], regs[lspnc_pkg::REG_ROW_W_23],
                   f[3], f[4], f[5]);
    ab = aw < 7;
    bb = bw < 7;
    r.eob = last;
    if (ab && bb) begin
      r.sx = 0; r.sy = 0; r.ex = 0; r.ey = 0; r.vis = 1'b0;
    end else begin
      if (ab || bb) begin
        num = 7 - aw;
        den = bw - aw;
        nm = (num < 0) ? longint'(-num) : num;
        dm = (den < 0) ? longint'(-den) : den;
        t30 = (nm << 30) / dm;
        cx = blend(ax, bx, t30);
        cy = blend(ay, by, t30);
        if (ab) begin
          ax = cx; ay = cy; aw = 7;
        end else begin
          bx = cx; by = cy; bw = 7;
        end
        clipped_cnt++;
      end
      r.sx = 32'(to_win(ax, aw, hw, 1'b0));
      r.sy = 32'(to_win(ay, aw, hh, 1'b1));
      r.ex = 32'(to_win(bx, bw, hw, 1'b0));
      r.ey = 32'(to_win(by, bw, hh, 1'b1));
      r.vis = 1'b1;
      visible_cnt++;
    end
    pending.insert(pending.size(), r);
  endfunction

  function void check_result(win_result_t got);
    win_result_t exp_r;
    if (pending.size() == 0) begin
      $error("unexpected result beat");
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    checked++;
    if (got.sx !== exp_r.sx) begin
      $error("win_start_x expected %0d got %0d", exp_r.sx, got.sx); errors++;
    end
    if (got.sy !== exp_r.sy) begin
      $error("win_start_y expected %0d got %0d", exp_r.sy, got.sy); errors++;
    end
    if (got.ex !== exp_r.ex) begin
      $error("win_end_x expected %0d got %0d", exp_r.ex, got.ex); errors++;
    end
    if (got.ey !== exp_r.ey) begin
      $error("win_end_y expected %0d got %0d", exp_r.ey, got.ey); errors++;
    end
    if (got.vis !== exp_r.vis) begin
      $error("visible expected %0b got %0b", exp_r.vis, got.vis); errors++;
    end
    if (got.eob !== exp_r.eob) begin
      $error("end_of_batch expected %0b got %0b", exp_r.eob, got.eob); errors++;
    end
  endfunction
endclass

module testbench;
  import lspnc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          idle_cycles = 0;
  int          sent = 0;

  lspnc_seg_if seg_ch ();
  lspnc_win_if win_ch ();

  seg_scoreboard sb = new();

  line_segment_project_near_clip i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_seg    (seg_ch.sink),
    .out_win   (win_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    seg_ch.valid = 1'b0;
    seg_ch.start_x = '0; seg_ch.start_y = '0; seg_ch.start_z = '0;
    seg_ch.end_x = '0; seg_ch.end_y = '0; seg_ch.end_z = '0;
    seg_ch.last_segment = 1'b0;
    win_ch.ready = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: the ready level is chosen at the falling edge.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        win_ch.ready <= 1'b0;
        hold--;
      end else begin
        win_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    win_result_t got;
    if (rst_n && win_ch.valid && win_ch.ready) begin
      got.sx = win_ch.win_start_x;
      got.sy = win_ch.win_start_y;
      got.ex = win_ch.win_end_x;
      got.ey = win_ch.win_end_y;
      got.vis = win_ch.visible;
      got.eob = win_ch.end_of_batch;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (seg_ch.valid && seg_ch.ready) || (win_ch.valid && win_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results still outstanding", sb.pending.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_segment(logic signed [31:0] f [6], logic last);
    int gap;
    seg_ch.valid <= 1'b1;
    seg_ch.start_x <= f[0]; seg_ch.start_y <= f[1]; seg_ch.start_z <= f[2];
    seg_ch.end_x <= f[3]; seg_ch.end_y <= f[4]; seg_ch.end_z <= f[5];
    seg_ch.last_segment <= last;
    @(posedge clk);
    while (!seg_ch.ready) @(posedge clk);
    sb.note_segment(f, last);
    sent++;
    @(negedge clk);
    gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      seg_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Called at a falling edge right after the last beat was offered.
  task automatic drain();
    seg_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] coef_small();
    return 32'($signed($urandom_range(0, 262144)) - 131072);
  endfunction

  function automatic logic signed [31:0] field_value(int mode);
    int r;
    r = $urandom_range(0, 9);
    if (mode == 0 || r < 5) return 32'($signed($urandom_range(0, 524288)) - 262144);
    if (r < 7) return $urandom();
    if (r == 7) return 32'sh7FFF_FFFF;
    if (r == 8) return 32'sh8000_0000;
    return 32'($signed($urandom_range(0, 16)) - 8);
  endfunction

  task automatic set_phase(int phase);
    logic [63:0] v;
    drain();
    case (phase)
      1: begin
        write_reg(REG_ROW_X_01, 64'h0000_0000_0001_0000);
        write_reg(REG_ROW_X_23, 64'h0);
        write_reg(REG_ROW_Y_01, 64'h0001_0000_0000_0000);
        write_reg(REG_ROW_Y_23, 64'h0);
        write_reg(REG_ROW_W_01, 64'h0);
        write_reg(REG_ROW_W_23, 64'h0000_0000_0001_0000);
        write_reg(REG_HALF_WIDTH, 64'd320 << 16);
        write_reg(REG_HALF_HEIGHT, 64'd240 << 16);
      end
      2, 5: begin
        for (int i = 0; i < 6; i++) begin
          write_reg(reg_idx_t'(i), {coef_small(), coef_small()});
        end
        write_reg(REG_HALF_WIDTH, (phase == 2) ? $urandom_range(0, 1 << 29) : 64'd1);
        write_reg(REG_HALF_HEIGHT, (phase == 2) ? $urandom_range(0, 1 << 29) : 64'd0);
      end
      3: begin
        for (int i = 0; i < 6; i++) begin
          v = {$urandom(), $urandom()};
          write_reg(reg_idx_t'(i), v);
        end
        write_reg(REG_HALF_WIDTH, 64'd1 << 29);
        write_reg(REG_HALF_HEIGHT, 64'd1 << 29);
      end
      default: begin
        write_reg(REG_ROW_X_01, 64'h8000_0000_7FFF_FFFF);
        write_reg(REG_ROW_X_23, 64'h7FFF_FFFF_8000_0000);
        write_reg(REG_ROW_Y_01, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_ROW_Y_23, 64'h0000_0000_0000_0000);
        write_reg(REG_ROW_W_01, 64'h0000_0001_FFFF_0000);
        write_reg(REG_ROW_W_23, 64'h0000_0007_0000_8000);
        write_reg(REG_HALF_WIDTH, 64'd1 << 29);
        write_reg(REG_HALF_HEIGHT, 64'd0);
      end
    endcase
  endtask

  initial begin
    logic signed [31:0] f [6];
    int mode;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed segments under the reset settings and a plain perspective.
    for (int ph = 0; ph < 2; ph++) begin
      if (ph == 1) set_phase(1);
      f = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
            32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
      send_segment(f, 1'b1);
      f = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
      send_segment(f, 1'b0);
      f = '{0, 0, 0, 0, 0, 0};
      send_segment(f, 1'b0);
      f = '{32'sh1_0000, 32'sh2_0000, -32'sh1_0000, 32'sh3_0000, 32'sh1_0000, -32'sh5};
      send_segment(f, 1'b0);
      f = '{32'sh1_0000, 32'sh2_0000, 32'sh4_0000, -32'sh3_0000, 32'sh1_0000, -32'sh2_0000};
      send_segment(f, 1'b1);
      f = '{-32'sh1_0000, 32'sh2_0000, -32'sh2_0000, 32'sh3_0000, 32'sh1_0000, 32'sh8_0000};
      send_segment(f, 1'b0);
      f = '{32'sh5_0000, -32'sh5_0000, 32'sd7, 32'sh5_0000, 32'sh5_0000, 32'sd6};
      send_segment(f, 1'b0);
      f = '{32'sh5_0000, -32'sh5_0000, 32'sd7, -32'sh5_0000, 32'sh5_0000, 32'sd7};
      send_segment(f, 1'b1);
      f = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd7, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd8};
      send_segment(f, 1'b0);
      f = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
      send_segment(f, 1'b1);
    end

    for (int ph = 0; ph < 6; ph++) begin
      set_phase(ph);
      for (int n = 0; n < 190; n++) begin
        mode = (ph == 3 || $urandom_range(0, 3) == 0) ? 1 : 0;
        for (int k = 0; k < 6; k++) f[k] = field_value(mode);
        send_segment(f, 1'($urandom_range(0, 1)));
      end
    end

    drain();
    $display("Sent %0d segments over six register settings; %0d results checked.",
             sent, sb.checked);
    $display("Of these %0d were visible and %0d were clipped at the near plane.",
             sb.visible_cnt, sb.clipped_cnt);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/lspnc_pkg.sv
hw/rtl/lspnc_seg_if.sv
hw/rtl/lspnc_win_if.sv
hw/rtl/lspnc_div.sv
hw/rtl/lspnc_xform.sv
hw/rtl/lspnc_clip.sv
hw/rtl/line_segment_project_near_clip.sv
dv/testbench.sv
